### design/ltds_pkg.sv
// ----------------------------------------------------------------------------
// ltds_pkg
// Shared types, register codes and address helpers for the layout transpose
// dma sequencer.
// ----------------------------------------------------------------------------
package ltds_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int DIM_W      = 16;

    // input item codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // layout_select bits
    localparam int LAYOUT_DST_CL_BIT = 0;
    localparam int LAYOUT_SRC_CL_BIT = 1;

    typedef enum logic [2:0] {
        REG_SRC_BASE    = 3'd0,
        REG_DST_BASE    = 3'd1,
        REG_WIDTH       = 3'd2,
        REG_HEIGHT      = 3'd3,
        REG_CHANNELS    = 3'd4,
        REG_LAYOUT      = 3'd5,
        REG_SRC_STRIDES = 3'd6,
        REG_DST_STRIDES = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0]      src_base;
        logic [31:0]      dst_base;
        logic [DIM_W-1:0] tensor_width;
        logic [DIM_W-1:0] tensor_height;
        logic [DIM_W-1:0] tensor_channels;
        logic [1:0]       layout_select;
        logic [31:0]      src_strides;
        logic [31:0]      dst_strides;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic        read_valid;
        logic [31:0] read_addr;
        logic        write_valid;
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic        done_res;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] chan;
    } pos_t;

    typedef struct packed {
        logic clear;
        logic first;
        logic step;
    } walk_ctl_t;

    // column fastest, then row, then channel
    function automatic pos_t advance(pos_t p, logic [DIM_W-1:0] wl, logic [DIM_W-1:0] hl);
        pos_t n;
        n = p;
        if (p.col == wl && p.row == hl) begin
            n.col  = '0;
            n.row  = '0;
            n.chan = p.chan + DIM_W'(1);
        end else if (p.col == wl) begin
            n.col = '0;
            n.row = p.row + DIM_W'(1);
        end else begin
            n.col = p.col + DIM_W'(1);
        end
        return n;
    endfunction

    function automatic logic [31:0] elem_addr(logic [31:0] base, logic [31:0] strides,
                                              logic chan_last, pos_t p);
        logic [31:0] pri;
        logic [31:0] sec;
        logic [31:0] off;
        pri = {16'b0, strides[15:0]};
        sec = {16'b0, strides[31:16]};
        if (chan_last) begin
            off = sec * {16'b0, p.col} + pri * {16'b0, p.row} + {16'b0, p.chan};
        end else begin
            off = sec * {16'b0, p.row} + pri * {16'b0, p.chan} + {16'b0, p.col};
        end
        return base + {off[29:0], 2'b00};
    endfunction

endpackage

### design/layout_transpose_dma_sequencer_top.sv
// ----------------------------------------------------------------------------
// layout_transpose_dma_sequencer_top
// Word-by-word tensor copy sequencer with channel-first / channel-last
// layout conversion on the source and destination sides.
// ----------------------------------------------------------------------------
// usage:
//   program the tensor geometry, bases, strides and layout over the apb port
//   while the block is idle, then send a start item (mode 0) on the s_ channel.
//   its result issues the read of source element zero. every read word comes
//   back as a data item (mode 1); its result carries the destination write and,
//   except at the last element, the next source read. the final write sets
//   done_res and the block returns to idle. items at the wrong time give an
//   all-zero result. every item gives exactly one result on the m_ channel.
// timing:
//   an accepted item is held in the input register and its result is then
//   loaded into the result register, which drives m_valid. while m_ready is
//   high one item per cycle is sustained; the address multipliers sit
//   between the input and result registers. a stalled m_ready holds the
//   result and the input register, and s_ready drops once both are full.
// reset:
//   synchronous, active low: block idle, counters zero, bases, strides and
//   layout zero, dimensions one.
// ----------------------------------------------------------------------------
module layout_transpose_dma_sequencer_top import ltds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cfg_t cfg;

    ltds_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ltds_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // the last write never issues another read
    a_done_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.write_valid && !m_data.read_valid)
        else $error("done item also issues a read");

    // a read without a write only comes from a start, at the source base
    a_start_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_valid && !m_data.write_valid
            |-> m_data.read_addr == cfg.src_base)
        else $error("start read not at source base");

    // no write means write fields are zero
    a_idle_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_valid
            |-> m_data.write_addr == 32'd0 && m_data.write_data == 32'd0
                && !m_data.done_res)
        else $error("write fields set without a write");

    // a run of quiet cycles with the result register empty leaves it empty
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(s_valid && s_ready)) [*2] |=> !m_valid)
        else $error("result appeared with no item");

endmodule

### design/ltds_regs.sv
// ----------------------------------------------------------------------------
// ltds_regs
// APB configuration registers of the transpose sequencer.
// ----------------------------------------------------------------------------
module ltds_regs import ltds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SRC_BASE:    cfg_next.src_base        = pwdata;
                REG_DST_BASE:    cfg_next.dst_base        = pwdata;
                REG_WIDTH:       cfg_next.tensor_width    = pwdata[DIM_W-1:0];
                REG_HEIGHT:      cfg_next.tensor_height   = pwdata[DIM_W-1:0];
                REG_CHANNELS:    cfg_next.tensor_channels = pwdata[DIM_W-1:0];
                REG_LAYOUT:      cfg_next.layout_select   = pwdata[1:0];
                REG_SRC_STRIDES: cfg_next.src_strides     = pwdata;
                REG_DST_STRIDES: cfg_next.dst_strides     = pwdata;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_SRC_BASE:    prdata = cfg_reg.src_base;
            REG_DST_BASE:    prdata = cfg_reg.dst_base;
            REG_WIDTH:       prdata = {16'b0, cfg_reg.tensor_width};
            REG_HEIGHT:      prdata = {16'b0, cfg_reg.tensor_height};
            REG_CHANNELS:    prdata = {16'b0, cfg_reg.tensor_channels};
            REG_LAYOUT:      prdata = {30'b0, cfg_reg.layout_select};
            REG_SRC_STRIDES: prdata = cfg_reg.src_strides;
            REG_DST_STRIDES: prdata = cfg_reg.dst_strides;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_base        <= '0;
            cfg_reg.dst_base        <= '0;
            cfg_reg.tensor_width    <= DIM_W'(1);
            cfg_reg.tensor_height   <= DIM_W'(1);
            cfg_reg.tensor_channels <= DIM_W'(1);
            cfg_reg.layout_select   <= '0;
            cfg_reg.src_strides     <= '0;
            cfg_reg.dst_strides     <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/ltds_walk.sv
// ----------------------------------------------------------------------------
// ltds_walk
// Tensor position counter: column, row and channel of one side of the copy.
// ----------------------------------------------------------------------------
module ltds_walk import ltds_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  walk_ctl_t        ctl,
    input  logic [DIM_W-1:0] width_last,
    input  logic [DIM_W-1:0] height_last,
    output pos_t             pos
);

    pos_t pos_reg;
    pos_t pos_next;

    assign pos = pos_reg;

    always_comb begin
        pos_next = pos_reg;
        if (ctl.clear) begin
            pos_next = '0;
        end else if (ctl.first) begin
            // one element past the origin
            pos_next = advance('0, width_last, height_last);
        end else if (ctl.step) begin
            pos_next = advance(pos_reg, width_last, height_last);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

### design/ltds_core.sv
// ----------------------------------------------------------------------------
// ltds_core
// Input register, transfer sequencing and result register.
// ----------------------------------------------------------------------------
module ltds_core import ltds_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic             in_valid_reg;
    logic             in_valid_next;
    in_item_t         in_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_data_reg;
    out_item_t        res;
    logic             busy_reg;
    logic             busy_next;
    logic             out_free;
    logic             fire;
    logic             dst_last;
    logic [DIM_W-1:0] wl;
    logic [DIM_W-1:0] hl;
    logic [DIM_W-1:0] cl;
    walk_ctl_t        src_ctl;
    walk_ctl_t        dst_ctl;
    pos_t             src_pos;
    pos_t             dst_pos;

    assign wl = cfg.tensor_width    - DIM_W'(1);
    assign hl = cfg.tensor_height   - DIM_W'(1);
    assign cl = cfg.tensor_channels - DIM_W'(1);

    assign out_free = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    assign dst_last = (dst_pos.col == wl) && (dst_pos.row == hl) && (dst_pos.chan == cl);

    ltds_walk u_src_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (src_ctl),
        .width_last  (wl),
        .height_last (hl),
        .pos         (src_pos)
    );

    ltds_walk u_dst_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (dst_ctl),
        .width_last  (wl),
        .height_last (hl),
        .pos         (dst_pos)
    );

    always_comb begin
        res       = '0;
        busy_next = busy_reg;
        src_ctl   = '0;
        dst_ctl   = '0;
        if (fire) begin
            if (in_data_reg.mode == MODE_START) begin
                if (!busy_reg) begin
                    busy_next      = 1'b1;
                    res.read_valid = 1'b1;
                    res.read_addr  = cfg.src_base;
                    src_ctl.first  = 1'b1;
                    dst_ctl.clear  = 1'b1;
                end
            end else if (busy_reg) begin
                res.write_valid = 1'b1;
                res.write_data  = in_data_reg.read_data;
                res.write_addr  = elem_addr(cfg.dst_base, cfg.dst_strides,
                                            cfg.layout_select[LAYOUT_DST_CL_BIT], dst_pos);
                if (dst_last) begin
                    res.done_res = 1'b1;
                    busy_next    = 1'b0;
                end else begin
                    // source runs one element ahead of the destination
                    res.read_valid = 1'b1;
                    res.read_addr  = elem_addr(cfg.src_base, cfg.src_strides,
                                               cfg.layout_select[LAYOUT_SRC_CL_BIT], src_pos);
                    src_ctl.step   = 1'b1;
                    dst_ctl.step   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= res;
        end
    end

endmodule
